### src/csmaa_pkg.sv
// shared types and constants for the class score moving average and argmax block
// no dependencies

package csmaa_pkg;

  typedef logic signed [7:0] score_t;
  typedef logic [3:0] class_t;
  typedef logic [4:0] count_t;

  typedef struct packed {
    class_t class_index;
    score_t averaged_score;
    logic   frame_done;
    class_t top_class;
  } result_t;

  localparam score_t SCORE_MIN = 8'sh80;
  localparam count_t CLASS_COUNT_RESET = 5'd12;
  localparam int RESULT_QDEPTH = 4;

endpackage

### src/csmaa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; read during write at the same address returns the old word

module csmaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/class_score_moving_average_argmax.sv
// moving average smoothing of classifier scores with a running argmax, top level
// depends on csmaa_pkg and csmaa_ram
//
// usage:
//   input channel in_valid/in_ready carries one signed score per request, classes in order,
//   class_count classes make one frame. output channel out_valid/out_ready carries one
//   result per request: class_index, window average of that class (truncated toward zero),
//   frame_done on the frame's last class and top_class (first highest average) with it.
//   cfg_we/cfg_wdata write class_count; write it only while idle.
// pipeline: an accepted request passes the stage 1 and stage 2 registers into the result queue,
//   which offers it on the output. throughput is one request per cycle while in_ready is high,
//   set by the history and sum memories (one read and one write port each) with write forwarding.
// reset: a clearing pass zeroes the score history and the class sums with in_ready low;
//   class_count returns to 12.
// stall: results wait in a four-entry result queue; with four requests in flight and none
//   taken, in_ready drops until the receiver takes one.

module class_score_moving_average_argmax #(
  parameter int WINDOW      = 4,
  parameter int MAX_CLASSES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  csmaa_pkg::count_t   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  csmaa_pkg::score_t   score,
  output logic                out_valid,
  input  logic                out_ready,
  output csmaa_pkg::class_t   class_index,
  output csmaa_pkg::score_t   averaged_score,
  output logic                frame_done,
  output csmaa_pkg::class_t   top_class
);

  import csmaa_pkg::*;

  localparam int HIST_DEPTH = WINDOW * MAX_CLASSES;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CLS_W      = $clog2(MAX_CLASSES);
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = 8 + $clog2(WINDOW);
  localparam int DIV_SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W    = DIV_SHIFT + 1;
  localparam int RECIP      = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int CMP_W      = ($clog2(MAX_CLASSES + 1) > 5) ? $clog2(MAX_CLASSES + 1) : 5;
  localparam int QPTR_W     = $clog2(RESULT_QDEPTH);
  localparam int QCNT_W     = $clog2(RESULT_QDEPTH + 1);

  // control
  logic               clearing;
  logic [HIST_AW-1:0] clr_addr;
  count_t             class_count;
  logic [CLS_W-1:0]   cls_cnt;
  logic [SLOT_W-1:0]  slot;
  logic [QCNT_W-1:0]  inflight;
  logic               in_acc;
  logic               out_acc;
  logic [CMP_W-1:0]   eff_count;
  logic               done_now;
  logic [HIST_AW-1:0] hist_raddr;

  // stage 1
  logic               s1_valid;
  score_t             s1_score;
  logic [CLS_W-1:0]   s1_cls;
  logic [HIST_AW-1:0] s1_haddr;
  logic               s1_done;
  logic               hist_hit;
  score_t             hist_fwd;
  logic               sum_hit;
  logic signed [SUM_W-1:0] sum_fwd;
  logic [7:0]         hist_rdata;
  logic [SUM_W-1:0]   sum_rdata;
  score_t             hist_old;
  logic signed [SUM_W-1:0] sum_old;
  logic signed [SUM_W-1:0] sum_new;

  // memory ports
  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr;
  logic [7:0]         hist_wdata;
  logic               sum_we;
  logic [CLS_W-1:0]   sum_waddr;
  logic [SUM_W-1:0]   sum_wdata;

  // stage 2
  logic               s2_valid;
  logic signed [SUM_W-1:0] s2_sum;
  logic [CLS_W-1:0]   s2_cls;
  logic               s2_done;
  logic               s2_neg;
  logic [SUM_W-1:0]   s2_mag;
  logic [PROD_W-1:0]  s2_prod;
  logic [7:0]         s2_quot;
  score_t             s2_avg;
  score_t             base_value;
  logic [CLS_W-1:0]   base_index;
  score_t             best_value;
  score_t             best_value_next;
  logic [CLS_W-1:0]   best_index;
  logic [CLS_W-1:0]   best_index_next;
  result_t            s2_result;

  // result queue
  result_t            q_mem [RESULT_QDEPTH];
  logic [QPTR_W-1:0]  q_wr;
  logic [QPTR_W-1:0]  q_rd;
  logic [QCNT_W-1:0]  q_count;

  assign in_ready  = !clearing && (inflight < QCNT_W'(RESULT_QDEPTH));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (q_count != '0);
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    if (class_count == '0) begin
      eff_count = CMP_W'(1);
    end else if (CMP_W'(class_count) > CMP_W'(MAX_CLASSES)) begin
      eff_count = CMP_W'(MAX_CLASSES);
    end else begin
      eff_count = CMP_W'(class_count);
    end
  end

  assign done_now   = (CMP_W'(cls_cnt) + CMP_W'(1)) >= eff_count;
  assign hist_raddr = HIST_AW'(slot) * HIST_AW'(MAX_CLASSES) + HIST_AW'(cls_cnt);

  // memory writes: clearing pass after reset, then stage 1 updates
  always_comb begin
    if (clearing) begin
      hist_we    = 1'b1;
      hist_waddr = clr_addr;
      hist_wdata = '0;
      sum_we     = ({1'b0, clr_addr} < (HIST_AW + 1)'(MAX_CLASSES));
      sum_waddr  = CLS_W'(clr_addr);
      sum_wdata  = '0;
    end else begin
      hist_we    = s1_valid;
      hist_waddr = s1_haddr;
      hist_wdata = s1_score;
      sum_we     = s1_valid;
      sum_waddr  = s1_cls;
      sum_wdata  = sum_new;
    end
  end

  csmaa_ram #(
    .WIDTH(8),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(hist_waddr),
    .wdata(hist_wdata),
    .raddr(hist_raddr),
    .rdata(hist_rdata)
  );

  csmaa_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_CLASSES)
  ) u_sums (
    .clk  (clk),
    .we   (sum_we),
    .waddr(sum_waddr),
    .wdata(sum_wdata),
    .raddr(cls_cnt),
    .rdata(sum_rdata)
  );

  // stage 1: running sum update
  always_comb begin
    hist_old = hist_hit ? hist_fwd : $signed(hist_rdata);
    sum_old  = sum_hit ? sum_fwd : $signed(sum_rdata);
    sum_new  = sum_old + SUM_W'(s1_score) - SUM_W'(hist_old);
  end

  // stage 2: divide by window and argmax
  always_comb begin
    s2_neg  = s2_sum[SUM_W-1];
    s2_mag  = s2_neg ? SUM_W'(-s2_sum) : SUM_W'(s2_sum);
    s2_prod = PROD_W'(s2_mag) * PROD_W'(RECIP);
    s2_quot = s2_prod[DIV_SHIFT +: 8];
    s2_avg  = s2_neg ? $signed(8'(-s2_quot)) : $signed(s2_quot);
    if (s2_cls == '0) begin
      base_value = SCORE_MIN;
      base_index = '0;
    end else begin
      base_value = best_value;
      base_index = best_index;
    end
    if (base_value < s2_avg) begin
      best_value_next = s2_avg;
      best_index_next = s2_cls;
    end else begin
      best_value_next = base_value;
      best_index_next = base_index;
    end
    s2_result.class_index    = class_t'(s2_cls);
    s2_result.averaged_score = s2_avg;
    s2_result.frame_done     = s2_done;
    s2_result.top_class      = s2_done ? class_t'(best_index_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_addr    <= '0;
      class_count <= CLASS_COUNT_RESET;
      cls_cnt     <= '0;
      slot        <= '0;
      inflight    <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      hist_hit    <= 1'b0;
      sum_hit     <= 1'b0;
      best_value  <= SCORE_MIN;
      best_index  <= '0;
      q_wr        <= '0;
      q_rd        <= '0;
      q_count     <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + HIST_AW'(1);
        if (clr_addr == HIST_AW'(HIST_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (cfg_we) begin
        class_count <= cfg_wdata;
      end
      if (in_acc) begin
        if (done_now) begin
          cls_cnt <= '0;
          slot    <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
        end else begin
          cls_cnt <= cls_cnt + CLS_W'(1);
        end
      end
      inflight <= inflight + QCNT_W'(in_acc) - QCNT_W'(out_acc);
      s1_valid <= in_acc;
      s2_valid <= s1_valid;
      hist_hit <= s1_valid && (s1_haddr == hist_raddr);
      sum_hit  <= s1_valid && (s1_cls == cls_cnt);
      if (s2_valid) begin
        best_value <= best_value_next;
        best_index <= best_index_next;
        q_wr       <= q_wr + QPTR_W'(1);
      end
      if (out_acc) begin
        q_rd <= q_rd + QPTR_W'(1);
      end
      q_count <= q_count + QCNT_W'(s2_valid) - QCNT_W'(out_acc);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_score <= score;
      s1_cls   <= cls_cnt;
      s1_haddr <= hist_raddr;
      s1_done  <= done_now;
    end
    hist_fwd <= s1_score;
    sum_fwd  <= sum_new;
    if (s1_valid) begin
      s2_sum  <= sum_new;
      s2_cls  <= s1_cls;
      s2_done <= s1_done;
    end
    if (s2_valid) begin
      q_mem[q_wr] <= s2_result;
    end
  end

  assign class_index    = q_mem[q_rd].class_index;
  assign averaged_score = q_mem[q_rd].averaged_score;
  assign frame_done     = q_mem[q_rd].frame_done;
  assign top_class      = q_mem[q_rd].top_class;

endmodule
